/* design/bpa_pkg.sv */
// bpa_pkg: shared constants, operation and status codes, payload types
// for the buffer pool age replacement block; no dependencies
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int AGE_BITS_DEF = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);

    localparam int KIND_W   = 3;
    localparam int FILE_W   = 8;
    localparam int BLOCK_W  = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EVICT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FILE_W-1:0]  file_id;
        logic [BLOCK_W-1:0] block_num;
        logic               dirty_in;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [FILE_W-1:0]   out_file;
        logic [BLOCK_W-1:0]  out_block;
        logic                write_back;
        logic                last;
    } rsp_item_t;

endpackage

/* design/bpa_chan_if.sv */
// bpa_chan_if: valid/ready channel carrying one payload item per transfer
// payload type is a parameter; no dependencies
`timescale 1ns / 1ps

interface bpa_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/buffer_pool_age_replacement_core.sv */
// buffer_pool_age_replacement_core: slot table of buffered blocks kept in one
// synchronous memory, valid marks in flops; depends on bpa_pkg, bpa_chan_if
// insert: result goes through the finish state into the output register; lookup, tick, evict, flush
// scan the memory one slot per cycle, unless a flush stalls, then finish the same way;
// a new item is accepted only in idle, once the last is done; the scan uses the single memory read port
// flush stalls its scan while its output register is still occupied
// reset clears the valid marks and control state; memory contents stay undefined
`timescale 1ns / 1ps

module buffer_pool_age_replacement_core
    import bpa_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int AGE_BITS = AGE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bpa_chan_if.sink   req,
    bpa_chan_if.source rsp
);

    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int ENT_W    = FILE_W + BLOCK_W + AGE_BITS + 1;
    localparam int AGE_LO   = 1;
    localparam int BLOCK_LO = AGE_LO + AGE_BITS;
    localparam int FILE_LO  = BLOCK_LO + BLOCK_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // control state
    logic [1:0]           state_reg, state_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 best_vld_reg, best_vld_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_vld_reg, out_vld_next;

    // payload
    logic [KIND_W-1:0]    op_reg, op_next;
    logic [FILE_W-1:0]    key_file_reg, key_file_next;
    logic [BLOCK_W-1:0]   key_block_reg, key_block_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [AGE_BITS-1:0]  best_age_reg, best_age_next;
    logic [FILE_W-1:0]    best_file_reg, best_file_next;
    logic [BLOCK_W-1:0]   best_block_reg, best_block_next;
    logic                 best_dirty_reg, best_dirty_next;
    rsp_item_t            out_data_reg;

    // memory
    logic [ENT_W-1:0]     mem [SLOTS];
    logic [ENT_W-1:0]     rdata_reg;
    logic                 rd_en, wr_en;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic [ENT_W-1:0]     wr_data;

    logic                 out_load;
    rsp_item_t            out_load_data;
    rsp_item_t            fin_res;
    rsp_item_t            pend_res;

    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic                 ent_v;
    logic [FILE_W-1:0]    ent_file;
    logic [BLOCK_W-1:0]   ent_block;
    logic [AGE_BITS-1:0]  ent_age;
    logic                 ent_dirty;
    logic                 flush_hit;
    logic                 can_emit;
    logic                 advance;
    req_item_t            req_item;

    assign req_item  = req.data;
    assign ent_v     = chk_vld_reg && valid_reg[chk_idx_reg];
    assign ent_file  = rdata_reg[FILE_LO +: FILE_W];
    assign ent_block = rdata_reg[BLOCK_LO +: BLOCK_W];
    assign ent_age   = rdata_reg[AGE_LO +: AGE_BITS];
    assign ent_dirty = rdata_reg[0];
    assign can_emit  = !out_vld_reg || rsp.ready;
    assign flush_hit = (state_reg == ST_SCAN) && (op_reg == KIND_FLUSH) && ent_v
                       && ent_dirty && (cnt_reg < RES_CNT_W'(MAX_RESULTS));
    assign advance   = !(flush_hit && pend_vld_reg && !can_emit);
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_data_reg;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // pending flush result, released when another dirty slot turns up
    always_comb
    begin
        pend_res            = '0;
        pend_res.status     = STAT_OK;
        pend_res.slot       = SLOT_W'(best_idx_reg);
        pend_res.out_file   = best_file_reg;
        pend_res.out_block  = best_block_reg;
        pend_res.write_back = 1'b1;
        pend_res.last       = 1'b0;
    end

    // final result of the item
    always_comb
    begin
        fin_res      = '0;
        fin_res.last = 1'b1;
        case (op_reg)
            KIND_LOOKUP:
            begin
                if (best_vld_reg)
                begin
                    fin_res.status    = STAT_OK;
                    fin_res.slot      = SLOT_W'(best_idx_reg);
                    fin_res.out_file  = key_file_reg;
                    fin_res.out_block = key_block_reg;
                end
                else
                begin
                    fin_res.status = STAT_MISS;
                end
            end
            KIND_INSERT:
            begin
                if (best_vld_reg)
                begin
                    fin_res.status = STAT_OK;
                    fin_res.slot   = SLOT_W'(best_idx_reg);
                end
                else
                begin
                    fin_res.status = STAT_FULL;
                end
            end
            KIND_EVICT:
            begin
                if (best_vld_reg)
                begin
                    fin_res.status     = STAT_OK;
                    fin_res.slot       = SLOT_W'(best_idx_reg);
                    fin_res.out_file   = best_file_reg;
                    fin_res.out_block  = best_block_reg;
                    fin_res.write_back = best_dirty_reg;
                end
                else
                begin
                    fin_res.status = STAT_EMPTY;
                end
            end
            KIND_FLUSH:
            begin
                if (pend_vld_reg)
                begin
                    fin_res.status     = STAT_OK;
                    fin_res.slot       = SLOT_W'(best_idx_reg);
                    fin_res.out_file   = best_file_reg;
                    fin_res.out_block  = best_block_reg;
                    fin_res.write_back = 1'b1;
                end
            end
            default:
            begin
                fin_res.status = STAT_OK;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        best_vld_next   = best_vld_reg;
        pend_vld_next   = pend_vld_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        key_file_next   = key_file_reg;
        key_block_next  = key_block_reg;
        best_idx_next   = best_idx_reg;
        best_age_next   = best_age_reg;
        best_file_next  = best_file_reg;
        best_block_next = best_block_reg;
        best_dirty_next = best_dirty_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        out_load        = 1'b0;
        out_load_data   = fin_res;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req_item.kind;
                    key_file_next  = req_item.file_id;
                    key_block_next = req_item.block_num;
                    best_vld_next  = 1'b0;
                    pend_vld_next  = 1'b0;
                    cnt_next       = '0;
                    case (req_item.kind)
                        KIND_INSERT:
                        begin
                            best_vld_next = free_found;
                            best_idx_next = free_idx;
                            if (free_found)
                            begin
                                valid_next[free_idx] = 1'b1;
                                wr_en   = 1'b1;
                                wr_addr = free_idx;
                                wr_data = {req_item.file_id, req_item.block_num,
                                           {AGE_BITS{1'b0}}, req_item.dirty_in};
                            end
                            state_next = ST_FIN;
                        end
                        KIND_LOOKUP, KIND_TICK, KIND_EVICT, KIND_FLUSH:
                        begin
                            rd_en        = 1'b1;
                            rd_addr      = '0;
                            chk_vld_next = 1'b1;
                            chk_idx_next = '0;
                            idx_next     = CNT_W'(1);
                            state_next   = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    if (ent_v)
                    begin
                        case (op_reg)
                            KIND_LOOKUP:
                            begin
                                if (!best_vld_reg && ent_file == key_file_reg
                                    && ent_block == key_block_reg)
                                begin
                                    best_vld_next = 1'b1;
                                    best_idx_next = chk_idx_reg;
                                end
                            end
                            KIND_TICK:
                            begin
                                if (ent_age != {AGE_BITS{1'b1}})
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = chk_idx_reg;
                                    wr_data = {ent_file, ent_block, ent_age + 1'b1,
                                               ent_dirty};
                                end
                            end
                            KIND_EVICT:
                            begin
                                if (!best_vld_reg || ent_age > best_age_reg)
                                begin
                                    best_vld_next   = 1'b1;
                                    best_idx_next   = chk_idx_reg;
                                    best_age_next   = ent_age;
                                    best_file_next  = ent_file;
                                    best_block_next = ent_block;
                                    best_dirty_next = ent_dirty;
                                end
                            end
                            KIND_FLUSH:
                            begin
                                if (flush_hit)
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = chk_idx_reg;
                                    wr_data = {ent_file, ent_block, ent_age, 1'b0};
                                    if (pend_vld_reg)
                                    begin
                                        out_load      = 1'b1;
                                        out_load_data = pend_res;
                                    end
                                    pend_vld_next   = 1'b1;
                                    best_idx_next   = chk_idx_reg;
                                    best_file_next  = ent_file;
                                    best_block_next = ent_block;
                                    cnt_next        = cnt_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                best_vld_next = best_vld_reg;
                            end
                        endcase
                    end

                    if (idx_reg < CNT_W'(SLOTS))
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = idx_reg[IDX_W-1:0];
                        chk_vld_next = 1'b1;
                        chk_idx_next = idx_reg[IDX_W-1:0];
                        idx_next     = idx_reg + 1'b1;
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                    end

                    if (chk_vld_reg && chk_idx_reg == IDX_W'(SLOTS - 1))
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (can_emit)
                begin
                    out_load = 1'b1;
                    if (op_reg == KIND_EVICT && best_vld_reg)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            idx_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            chk_idx_reg  <= '0;
            best_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            idx_reg      <= idx_next;
            chk_vld_reg  <= chk_vld_next;
            chk_idx_reg  <= chk_idx_next;
            best_vld_reg <= best_vld_next;
            pend_vld_reg <= pend_vld_next;
            cnt_reg      <= cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_file_reg   <= key_file_next;
        key_block_reg  <= key_block_next;
        best_idx_reg   <= best_idx_next;
        best_age_reg   <= best_age_next;
        best_file_reg  <= best_file_next;
        best_block_reg <= best_block_next;
        best_dirty_reg <= best_dirty_next;
        if (out_load)
        begin
            out_data_reg <= out_load_data;
        end
    end

    // slot table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // scan writes back behind its read address, never onto it
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("memory read and write hit the same slot");

    a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req_item.kind == KIND_INSERT && free_found)
        |=> valid_reg[$past(free_idx)])
        else $error("inserted slot not marked valid");

    a_evict_was_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && can_emit && op_reg == KIND_EVICT && best_vld_reg)
        |-> valid_reg[best_idx_reg])
        else $error("evicted slot was not valid");

    // the last dirty slot of a flush may hand over to the final transfer
    a_partial_flush_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !out_load_data.last) |=> (state_reg != ST_IDLE))
        else $error("non-final flush transfer left the scan");

endmodule

/* tb/tb_buffer_pool_age_replacement_core.sv */
// tb_buffer_pool_age_replacement_core: self-checking bench for the buffer pool age replacement
// core, with a random-gap driver, a stalling sink and an in-bench slot table predictor
// depends on bpa_pkg, bpa_chan_if and buffer_pool_age_replacement_core
`timescale 1ns / 1ps

module tb_buffer_pool_age_replacement_core;
    import bpa_pkg::*;

    localparam int TB_SLOTS    = 16;
    localparam int TB_AGE_BITS = AGE_BITS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_OPS    = 400;
    localparam logic [TB_AGE_BITS-1:0] AGE_TOP = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bpa_chan_if #(.T(req_item_t)) req_if ();
    bpa_chan_if #(.T(rsp_item_t)) rsp_if ();

    buffer_pool_age_replacement_core #(
        .SLOTS    (TB_SLOTS),
        .AGE_BITS (TB_AGE_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic      drv_valid  = 1'b0;
    req_item_t drv_item   = '0;
    logic      sink_ready = 1'b0;
    logic      req_took   = 1'b0;
    int        gap_left   = 0;
    int        ready_left = 0;
    int        cycle_count = 0;
    int        mismatches = 0;

    assign req_if.valid = drv_valid;
    assign req_if.data  = drv_item;
    assign rsp_if.ready = sink_ready;

    req_item_t op_backlog [$];
    rsp_item_t pool_replies [$];

    logic                   pool_valid [TB_SLOTS] = '{default: 1'b0};
    logic [FILE_W-1:0]      pool_file  [TB_SLOTS] = '{default: '0};
    logic [BLOCK_W-1:0]     pool_block [TB_SLOTS] = '{default: '0};
    logic [TB_AGE_BITS-1:0] pool_age   [TB_SLOTS] = '{default: '0};
    logic                   pool_dirty [TB_SLOTS] = '{default: 1'b0};

    // apply one operation to the slot table and queue the replies it causes
    task automatic apply_pool_op(input req_item_t op);
        rsp_item_t r;
        int        i;
        int        pick;
        int        n;
        r = '0;
        r.last = 1'b1;
        pick = -1;
        n = 0;
        case (op.kind)
            KIND_LOOKUP:
            begin
                for (i = 0; i < TB_SLOTS; i++)
                    if (pick < 0 && pool_valid[i] && pool_file[i] == op.file_id
                        && pool_block[i] == op.block_num)
                        pick = i;
                if (pick < 0)
                    r.status = STAT_MISS;
                else
                begin
                    r.slot      = pick[SLOT_W-1:0];
                    r.out_file  = op.file_id;
                    r.out_block = op.block_num;
                end
                pool_replies.push_back(r);
            end
            KIND_INSERT:
            begin
                for (i = 0; i < TB_SLOTS; i++)
                    if (pick < 0 && !pool_valid[i])
                        pick = i;
                if (pick < 0)
                    r.status = STAT_FULL;
                else
                begin
                    pool_valid[pick] = 1'b1;
                    pool_file[pick]  = op.file_id;
                    pool_block[pick] = op.block_num;
                    pool_age[pick]   = '0;
                    pool_dirty[pick] = op.dirty_in;
                    r.slot = pick[SLOT_W-1:0];
                end
                pool_replies.push_back(r);
            end
            KIND_TICK:
            begin
                for (i = 0; i < TB_SLOTS; i++)
                    if (pool_valid[i] && pool_age[i] != AGE_TOP)
                        pool_age[i] = pool_age[i] + 1'b1;
                pool_replies.push_back(r);
            end
            KIND_EVICT:
            begin
                for (i = 0; i < TB_SLOTS; i++)
                    if (pool_valid[i] && (pick < 0 || pool_age[i] > pool_age[pick]))
                        pick = i;
                if (pick < 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.slot       = pick[SLOT_W-1:0];
                    r.out_file   = pool_file[pick];
                    r.out_block  = pool_block[pick];
                    r.write_back = pool_dirty[pick];
                    pool_valid[pick] = 1'b0;
                    pool_age[pick]   = '0;
                    pool_dirty[pick] = 1'b0;
                end
                pool_replies.push_back(r);
            end
            KIND_FLUSH:
            begin
                for (i = 0; i < TB_SLOTS; i++)
                begin
                    if (n < MAX_RESULTS && pool_valid[i] && pool_dirty[i])
                    begin
                        pool_dirty[i] = 1'b0;
                        r.slot       = i[SLOT_W-1:0];
                        r.out_file   = pool_file[i];
                        r.out_block  = pool_block[i];
                        r.write_back = 1'b1;
                        r.last       = 1'b0;
                        pool_replies.push_back(r);
                        n++;
                    end
                end
                if (n == 0)
                    pool_replies.push_back(r);
                else
                    pool_replies[pool_replies.size() - 1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int idle_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (((cycle_count / 3000) % 4) == 1)
            return 0;
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic req_item_t make_op(logic [KIND_W-1:0] k, logic [FILE_W-1:0] f,
                                          logic [BLOCK_W-1:0] b, logic d);
        req_item_t op;
        op.kind      = k;
        op.file_id   = f;
        op.block_num = b;
        op.dirty_in  = d;
        return op;
    endfunction

    // driver: presents queued items, holds each until its transfer
    always @(negedge clk)
    begin
        logic      next_valid;
        req_item_t next_item;
        next_valid = drv_valid;
        next_item  = drv_item;
        if (rst_n)
        begin
            if (drv_valid && req_took)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (op_backlog.size() > 0)
                begin
                    next_item  = op_backlog.pop_front();
                    next_valid = 1'b1;
                    gap_left   = idle_span();
                end
            end
        end
        drv_valid <= next_valid;
        drv_item  <= next_item;
    end

    // sink: random back-pressure on the result channel
    always @(negedge clk)
    begin
        if (ready_left > 0)
            ready_left--;
        else if (((cycle_count / 3000) % 4) == 1 || $urandom_range(0, 99) < 70)
        begin
            sink_ready <= 1'b1;
            ready_left = $urandom_range(0, 15);
        end
        else
        begin
            sink_ready <= 1'b0;
            ready_left = idle_span();
        end
    end

    // monitor: check results first, then predict from the accepted item
    always @(posedge clk)
    begin
        rsp_item_t got;
        rsp_item_t want;
        cycle_count <= cycle_count + 1;
        req_took <= req_if.valid && req_if.ready;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.data;
            if (pool_replies.size() == 0)
            begin
                $display("%0t: no result expected, got %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = pool_replies.pop_front();
                check_field("status", want.status, got.status);
                check_field("slot", want.slot, got.slot);
                check_field("out_file", want.out_file, got.out_file);
                check_field("out_block", want.out_block, got.out_block);
                check_field("write_back", want.write_back, got.write_back);
                check_field("last", want.last, got.last);
            end
        end
        if (rst_n && req_if.valid && req_if.ready)
            apply_pool_op(req_if.data);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [FILE_W-1:0]  seen_file [$];
        logic [BLOCK_W-1:0] seen_block [$];
        logic [KIND_W-1:0]  k;
        logic [FILE_W-1:0]  f;
        logic [BLOCK_W-1:0] b;
        int issued;
        int roll;
        int pick;
        int n;
        bit fill_phase;

        // empty table cases
        op_backlog.push_back(make_op(KIND_EVICT, 8'h00, 16'h0000, 1'b0));
        op_backlog.push_back(make_op(KIND_LOOKUP, 8'hff, 16'hffff, 1'b1));
        op_backlog.push_back(make_op(KIND_FLUSH, 8'h00, 16'h0000, 1'b0));
        // field extremes, hit and partial-match miss
        op_backlog.push_back(make_op(KIND_INSERT, 8'h00, 16'h0000, 1'b0));
        op_backlog.push_back(make_op(KIND_INSERT, 8'hff, 16'hffff, 1'b1));
        op_backlog.push_back(make_op(KIND_LOOKUP, 8'hff, 16'hffff, 1'b0));
        op_backlog.push_back(make_op(KIND_LOOKUP, 8'h00, 16'hffff, 1'b0));
        // unused kinds are ignored
        op_backlog.push_back(make_op(3'd5, 8'h5a, 16'ha5a5, 1'b1));
        op_backlog.push_back(make_op(3'd7, 8'ha5, 16'h5a5a, 1'b0));
        op_backlog.push_back(make_op(KIND_TICK, 8'h00, 16'h0000, 1'b0));
        op_backlog.push_back(make_op(KIND_FLUSH, 8'h00, 16'h0000, 1'b0));
        // fill up, then insert into a full table and evict with a tie
        for (n = 0; n < TB_SLOTS - 2; n++)
            op_backlog.push_back(make_op(KIND_INSERT, 8'($urandom), 16'($urandom),
                                         1'($urandom)));
        op_backlog.push_back(make_op(KIND_INSERT, 8'h12, 16'h3456, 1'b1));
        op_backlog.push_back(make_op(KIND_EVICT, 8'h00, 16'h0000, 1'b0));

        issued = 0;
        while (issued < RAND_OPS)
        begin
            fill_phase = ((issued / 40) % 2) == 0;
            roll = $urandom_range(0, 99);
            f = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            b = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
            if (roll < 5)
                k = 3'($urandom_range(5, 7));
            else if (roll < 30)
            begin
                k = KIND_LOOKUP;
                if (seen_file.size() > 0 && $urandom_range(0, 2) != 0)
                begin
                    pick = $urandom_range(0, seen_file.size() - 1);
                    b = seen_block[pick];
                    if ($urandom_range(0, 5) != 0)
                        f = seen_file[pick];
                end
            end
            else if (roll < (fill_phase ? 66 : 38))
            begin
                k = KIND_INSERT;
                seen_file.push_back(f);
                seen_block.push_back(b);
                if (seen_file.size() > 32)
                begin
                    void'(seen_file.pop_front());
                    void'(seen_block.pop_front());
                end
            end
            else if (roll < (fill_phase ? 82 : 60))
                k = KIND_TICK;
            else if (roll < (fill_phase ? 88 : 92))
                k = KIND_EVICT;
            else
                k = KIND_FLUSH;
            op_backlog.push_back(make_op(k, f, b, 1'($urandom)));
            if (k <= KIND_FLUSH)
                issued++;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (op_backlog.size() > 0 || drv_valid)
            @(posedge clk);
        while (pool_replies.size() > 0)
            @(posedge clk);
        repeat (4 * TB_SLOTS) @(posedge clk);

        if (mismatches == 0 && pool_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
